// File: rtl/core/huffman_code_builder_core_defines.svh
// ----------------------------------------------------------------------------
// Huffman code builder: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define HCB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcb: implication check failed");

// next-cycle implication, quiet during reset
`define HCB_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcb: next-cycle check failed");

`endif

// File: rtl/core/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Types, widths and micro-op codes shared by the Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

	localparam int ALPHA_SIZE   = 256;
	localparam int SYM_W        = 8;
	localparam int SLOT_W       = 8;
	localparam int IDX_W        = 8;
	localparam int CNT_W        = 24;
	localparam int WT_W         = CNT_W + 8;
	localparam int NODE_W       = 9;
	localparam int NODE_CAP     = 2 * ALPHA_SIZE - 1;
	localparam int MAX_CODE_LEN = 48;
	localparam int CODE_W       = 48;
	localparam int LEN_W        = 6;
	localparam int DIST_W       = 9;
	localparam int DEPTH_W      = 9;
	localparam int HEAP_AW      = 8;
	localparam int STK_DEPTH    = ALPHA_SIZE + 1;
	localparam int STK_AW       = 9;
	localparam int OP_W         = 2;
	localparam int STAT_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_COUNT  = 2'd0,
		OP_FINISH = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_ERR  = 2'd1;
	localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [WT_W-1:0]   wt;
	} heap_ent_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
	} child_t;

	typedef struct packed {
		logic              too_long;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} code_ent_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [DEPTH_W-1:0] depth;
		logic [CODE_W-1:0]  bits;
	} frame_t;

	typedef enum logic [4:0] {
		UOP_NONE,
		UOP_CNT_LOOK,
		UOP_CNT_INC,
		UOP_RD_OUT,
		UOP_FIN_INIT,
		UOP_CP_WR,
		UOP_HPY_INIT,
		UOP_HPY_NEXT,
		UOP_SD_LDX,
		UOP_SD_LDX2,
		UOP_SD_L,
		UOP_SD_R,
		UOP_SD_CMP,
		UOP_EX_TOP,
		UOP_EX_LAST,
		UOP_EX_SET,
		UOP_MERGE,
		UOP_IN_CHK,
		UOP_IN_CMP,
		UOP_ROOT_RD,
		UOP_WK_INIT,
		UOP_WK_LEAF,
		UOP_WK_PUSH,
		UOP_WK_POP,
		UOP_WK_LOAD,
		UOP_FIN_OUT
	} uop_t;

	typedef struct packed {
		logic in_fire;
		uop_t uop;
	} hcb_cmd_t;

	typedef struct packed {
		logic hit;
		logic n_zero;
		logic n_ge2;
		logic cp_last;
		logic hpy_last;
		logic sd_stop;
		logic in_root;
		logic in_stop;
		logic heap_multi;
		logic is_leaf;
		logic push_ok;
		logic sp_zero;
		logic out_free;
	} hcb_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the contents before a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: counting, table reads, heap build/merge and the tree walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [hcb_pkg::OP_W-1:0]  op,
	output logic                           in_ready,
	input  wire hcb_pkg::hcb_stat_t        stat,
	output hcb_pkg::hcb_cmd_t              cmd
);

	import hcb_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_C0, S_C1, S_C2, S_RD0, S_RD1,
		S_FI, S_CPR, S_CPW, S_HI, S_HN,
		S_LDX, S_LDX2, S_SDL, S_SDR, S_SDC,
		S_MCHK, S_EX0, S_EX1, S_EX2, S_MRG, S_INC, S_INP,
		S_ROOT, S_WI, S_WN, S_WL, S_WP, S_POP, S_LD, S_FO
	} state_t;

	typedef enum logic [1:0] {
		RET_HPY,
		RET_A,
		RET_B
	} ret_t;

	state_t state_q;
	ret_t   ret_q;
	logic   fire;

	assign in_ready = (state_q == S_IDLE);
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_HPY;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						unique case (op_t'(op))
							OP_COUNT:  state_q <= S_C0;
							OP_FINISH: state_q <= S_FI;
							OP_READ:   state_q <= S_RD0;
							OP_NOP:    state_q <= S_IDLE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_C0: state_q <= S_C1;
				S_C1: state_q <= stat.hit ? S_C2 : S_IDLE;
				S_C2: state_q <= S_IDLE;
				S_RD0: state_q <= S_RD1;
				S_RD1: if (stat.out_free) state_q <= S_IDLE;
				S_FI: state_q <= stat.n_zero ? S_FO : S_CPR;
				S_CPR: state_q <= S_CPW;
				S_CPW: begin
					if (!stat.cp_last)
						state_q <= S_CPR;
					else if (stat.n_ge2)
						state_q <= S_HI;
					else
						state_q <= S_MCHK;
				end
				S_HI: begin
					ret_q   <= RET_HPY;
					state_q <= S_LDX;
				end
				S_HN: state_q <= S_LDX;
				S_LDX: state_q <= S_LDX2;
				S_LDX2: state_q <= S_SDL;
				S_SDL: state_q <= S_SDR;
				S_SDR: state_q <= S_SDC;
				S_SDC: begin
					if (!stat.sd_stop) begin
						state_q <= S_SDL;
					end else begin
						unique case (ret_q)
							RET_HPY: state_q <= stat.hpy_last ? S_MCHK : S_HN;
							RET_A: begin
								ret_q   <= RET_B;
								state_q <= S_EX0;
							end
							RET_B:   state_q <= S_MRG;
							default: state_q <= S_MRG;
						endcase
					end
				end
				S_MCHK: begin
					if (stat.heap_multi) begin
						ret_q   <= RET_A;
						state_q <= S_EX0;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_EX0: state_q <= S_EX1;
				S_EX1: state_q <= S_EX2;
				S_EX2: state_q <= S_SDL;
				S_MRG: state_q <= S_INC;
				S_INC: state_q <= stat.in_root ? S_MCHK : S_INP;
				S_INP: state_q <= stat.in_stop ? S_MCHK : S_INC;
				S_ROOT: state_q <= S_WI;
				S_WI: state_q <= S_WN;
				S_WN: begin
					if (stat.is_leaf)
						state_q <= S_WL;
					else if (stat.push_ok)
						state_q <= S_WP;
					else
						state_q <= stat.sp_zero ? S_FO : S_POP;
				end
				S_WL: state_q <= stat.sp_zero ? S_FO : S_POP;
				S_WP: state_q <= S_WN;
				S_POP: state_q <= S_LD;
				S_LD: state_q <= S_WN;
				S_FO: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.in_fire = fire;
		unique case (state_q)
			S_C1:   cmd.uop = UOP_CNT_LOOK;
			S_C2:   cmd.uop = UOP_CNT_INC;
			S_RD1:  cmd.uop = stat.out_free ? UOP_RD_OUT : UOP_NONE;
			S_FI:   cmd.uop = UOP_FIN_INIT;
			S_CPW:  cmd.uop = UOP_CP_WR;
			S_HI:   cmd.uop = UOP_HPY_INIT;
			S_HN:   cmd.uop = UOP_HPY_NEXT;
			S_LDX:  cmd.uop = UOP_SD_LDX;
			S_LDX2: cmd.uop = UOP_SD_LDX2;
			S_SDL:  cmd.uop = UOP_SD_L;
			S_SDR:  cmd.uop = UOP_SD_R;
			S_SDC:  cmd.uop = UOP_SD_CMP;
			S_EX0:  cmd.uop = UOP_EX_TOP;
			S_EX1:  cmd.uop = UOP_EX_LAST;
			S_EX2:  cmd.uop = UOP_EX_SET;
			S_MRG:  cmd.uop = UOP_MERGE;
			S_INC:  cmd.uop = UOP_IN_CHK;
			S_INP:  cmd.uop = UOP_IN_CMP;
			S_ROOT: cmd.uop = UOP_ROOT_RD;
			S_WI:   cmd.uop = UOP_WK_INIT;
			S_WL:   cmd.uop = UOP_WK_LEAF;
			S_WP:   cmd.uop = UOP_WK_PUSH;
			S_POP:  cmd.uop = UOP_WK_POP;
			S_LD:   cmd.uop = UOP_WK_LOAD;
			S_FO:   cmd.uop = stat.out_free ? UOP_FIN_OUT : UOP_NONE;
			default: cmd.uop = UOP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/hcb_dp.sv
// ----------------------------------------------------------------------------
// hcb_dp
// Datapath: symbol/count tables, heap and node stores, walk stack, code table.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hcb_pkg::hcb_cmd_t           cmd,
	output hcb_pkg::hcb_stat_t               stat,
	input  wire logic [hcb_pkg::SYM_W-1:0]   data_byte,
	input  wire logic [hcb_pkg::IDX_W-1:0]   entry_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [hcb_pkg::DIST_W-1:0]       symbol_count,
	output logic [hcb_pkg::SYM_W-1:0]        entry_symbol,
	output logic [hcb_pkg::CODE_W-1:0]       code_bits,
	output logic [hcb_pkg::LEN_W-1:0]        code_length,
	output logic [hcb_pkg::STAT_W-1:0]       status
);

	import hcb_pkg::*;

	// control state
	logic [ALPHA_SIZE-1:0] seen_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  built_q;
	logic                  any_long_q;
	logic                  out_valid_q;

	// payload / working registers
	logic [SYM_W-1:0]      byte_q;
	logic [IDX_W-1:0]      idx_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [DIST_W-1:0]     i_q;
	logic [HEAP_AW-1:0]    k_q;
	logic [DIST_W-1:0]     hsize_q;
	logic [NODE_W-1:0]     next_q;
	heap_ent_t             x_q, l_q, a_q, b_q;
	frame_t                cur_q;
	logic [STK_AW-1:0]     sp_q;
	logic [IDX_W-1:0]      wout_q;

	logic [DIST_W-1:0]     sym_cnt_q;
	logic [SYM_W-1:0]      ent_sym_q;
	logic [CODE_W-1:0]     code_bits_q;
	logic [LEN_W-1:0]      code_len_q;
	logic [STAT_W-1:0]     status_q;

	// memory ports
	logic [SLOT_W-1:0]     map_rdata;
	logic [SYM_W-1:0]      sym_rdata;
	logic [CNT_W-1:0]      cnt_rdata;
	logic                  cnt_we;
	logic [SLOT_W-1:0]     cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]      cnt_wdata;
	heap_ent_t             heap_rdata, heap_wdata;
	logic                  heap_we;
	logic [HEAP_AW-1:0]    heap_waddr, heap_raddr;
	child_t                child_rdata;
	frame_t                stk_rdata, stk_wdata;
	code_ent_t             code_rdata, code_wdata;

	// derived
	logic                  new_sym;
	logic [9:0]            lc, rc, hsize_x;
	logic                  l_ok, r_ok;
	logic [WT_W-1:0]       small_wt;
	heap_ent_t             sd_pick;
	logic [HEAP_AW-1:0]    sd_k;
	logic [HEAP_AW-1:0]    km1, parent;
	logic [DIST_W-1:0]     hm1, nm2, im1, dm1;
	logic [STK_AW-1:0]     spm1;
	logic                  too_long;
	logic [DEPTH_W-1:0]    depth_p1;
	uop_t                  uop;

	assign uop = cmd.uop;

	assign new_sym = (uop == UOP_CNT_LOOK) && !seen_q[byte_q] &&
		(dist_q < DIST_W'(ALPHA_SIZE));

	assign lc      = {1'b0, k_q, 1'b1};
	assign rc      = lc + 10'd1;
	assign hsize_x = {1'b0, hsize_q};
	assign l_ok    = (lc < hsize_x) && (l_q.wt < x_q.wt);
	assign small_wt = l_ok ? l_q.wt : x_q.wt;
	assign r_ok    = (rc < hsize_x) && (heap_rdata.wt < small_wt);
	assign sd_pick = r_ok ? heap_rdata : l_q;
	assign sd_k    = r_ok ? rc[HEAP_AW-1:0] : lc[HEAP_AW-1:0];
	assign km1     = k_q - 1'b1;
	assign parent  = {1'b0, km1[HEAP_AW-1:1]};
	assign hm1     = hsize_q - 1'b1;
	assign nm2     = dist_q - DIST_W'(2);
	assign im1     = i_q - 1'b1;
	assign dm1     = dist_q - 1'b1;
	assign spm1    = sp_q - 1'b1;
	assign too_long = cur_q.depth > DEPTH_W'(MAX_CODE_LEN);
	assign depth_p1 = cur_q.depth + 1'b1;

	// status to the sequencer
	always_comb begin
		stat.hit        = seen_q[byte_q];
		stat.n_zero     = (dist_q == '0);
		stat.n_ge2      = (dist_q >= DIST_W'(2));
		stat.cp_last    = (i_q == dm1);
		stat.hpy_last   = (i_q == '0);
		stat.sd_stop    = !l_ok && !r_ok;
		stat.in_root    = (k_q == '0);
		stat.in_stop    = !(x_q.wt < heap_rdata.wt);
		stat.heap_multi = (hsize_q > DIST_W'(1));
		stat.is_leaf    = (cur_q.node < dist_q);
		stat.push_ok    = (sp_q <= STK_AW'(STK_DEPTH - 2));
		stat.sp_zero    = (sp_q == '0);
		stat.out_free   = !out_valid_q || out_ready;
	end

	// byte -> slot map, slot -> symbol, slot -> count
	hcb_ram #(.WIDTH(SLOT_W), .DEPTH(ALPHA_SIZE)) u_map (
		.clk(clk), .we(new_sym), .waddr(byte_q), .wdata(dist_q[SLOT_W-1:0]),
		.raddr(byte_q), .rdata(map_rdata)
	);

	hcb_ram #(.WIDTH(SYM_W), .DEPTH(ALPHA_SIZE)) u_sym (
		.clk(clk), .we(new_sym), .waddr(dist_q[SLOT_W-1:0]), .wdata(byte_q),
		.raddr(cur_q.node[SLOT_W-1:0]), .rdata(sym_rdata)
	);

	always_comb begin
		cnt_we    = new_sym || (uop == UOP_CNT_INC);
		cnt_waddr = (uop == UOP_CNT_INC) ? slot_q : dist_q[SLOT_W-1:0];
		if (uop == UOP_CNT_INC)
			cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
		else
			cnt_wdata = CNT_W'(1);
		cnt_raddr = (uop == UOP_CNT_LOOK) ? map_rdata : i_q[SLOT_W-1:0];
	end

	hcb_ram #(.WIDTH(CNT_W), .DEPTH(ALPHA_SIZE)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	// heap of (node, weight) pairs
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = k_q;
		heap_wdata = x_q;
		heap_raddr = '0;
		case (uop)
			UOP_CP_WR: begin
				heap_we    = 1'b1;
				heap_waddr = i_q[HEAP_AW-1:0];
				heap_wdata = '{node: i_q, wt: WT_W'(cnt_rdata)};
			end
			UOP_SD_CMP: begin
				heap_we    = 1'b1;
				heap_wdata = (!l_ok && !r_ok) ? x_q : sd_pick;
			end
			UOP_IN_CHK: begin
				heap_we    = (k_q == '0);
				heap_raddr = parent;
			end
			UOP_IN_CMP: begin
				heap_we    = 1'b1;
				heap_wdata = (x_q.wt < heap_rdata.wt) ? heap_rdata : x_q;
			end
			UOP_SD_LDX:  heap_raddr = k_q;
			UOP_EX_LAST: heap_raddr = hm1[HEAP_AW-1:0];
			UOP_SD_L:    heap_raddr = lc[HEAP_AW-1:0];
			UOP_SD_R:    heap_raddr = rc[HEAP_AW-1:0];
			default: ;
		endcase
	end

	hcb_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(ALPHA_SIZE)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	hcb_ram #(.WIDTH($bits(child_t)), .DEPTH(NODE_CAP)) u_child (
		.clk(clk), .we(uop == UOP_MERGE), .waddr(next_q),
		.wdata(child_t'{left: a_q.node, right: b_q.node}),
		.raddr(cur_q.node), .rdata(child_rdata)
	);

	assign stk_wdata = '{node: child_rdata.right, depth: depth_p1,
		bits: {cur_q.bits[CODE_W-2:0], 1'b1}};

	hcb_ram #(.WIDTH($bits(frame_t)), .DEPTH(STK_DEPTH)) u_stk (
		.clk(clk), .we(uop == UOP_WK_PUSH), .waddr(sp_q), .wdata(stk_wdata),
		.raddr(spm1), .rdata(stk_rdata)
	);

	always_comb begin
		code_wdata.too_long = too_long;
		code_wdata.sym      = sym_rdata;
		code_wdata.bits     = too_long ? '0 : cur_q.bits;
		code_wdata.len      = too_long ? '0 : cur_q.depth[LEN_W-1:0];
	end

	hcb_ram #(.WIDTH($bits(code_ent_t)), .DEPTH(ALPHA_SIZE)) u_code (
		.clk(clk), .we(uop == UOP_WK_LEAF), .waddr(wout_q), .wdata(code_wdata),
		.raddr(idx_q), .rdata(code_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			dist_q      <= '0;
			built_q     <= 1'b0;
			any_long_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (new_sym) begin
				seen_q[byte_q] <= 1'b1;
				dist_q         <= dist_q + 1'b1;
			end
			if (uop == UOP_CNT_LOOK)
				built_q <= 1'b0;
			if (uop == UOP_FIN_INIT) begin
				built_q    <= 1'b1;
				any_long_q <= 1'b0;
			end
			if (uop == UOP_WK_LEAF && too_long)
				any_long_q <= 1'b1;
			if (uop == UOP_RD_OUT || uop == UOP_FIN_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.in_fire) begin
			byte_q <= data_byte;
			idx_q  <= entry_index;
		end
		case (uop)
			UOP_CNT_LOOK: slot_q <= map_rdata;
			UOP_FIN_INIT: begin
				i_q     <= '0;
				hsize_q <= dist_q;
				next_q  <= dist_q;
			end
			UOP_CP_WR: i_q <= i_q + 1'b1;
			UOP_HPY_INIT: begin
				i_q <= {1'b0, nm2[DIST_W-1:1]};
				k_q <= nm2[DIST_W-1:1];
			end
			UOP_HPY_NEXT: begin
				i_q <= im1;
				k_q <= im1[HEAP_AW-1:0];
			end
			UOP_SD_LDX2: x_q <= heap_rdata;
			UOP_SD_R:    l_q <= heap_rdata;
			UOP_SD_CMP:  if (l_ok || r_ok) k_q <= sd_k;
			UOP_EX_LAST: begin
				b_q <= heap_rdata;
				a_q <= b_q;
			end
			UOP_EX_SET: begin
				x_q     <= heap_rdata;
				hsize_q <= hm1;
				k_q     <= '0;
			end
			UOP_MERGE: begin
				x_q     <= '{node: next_q, wt: a_q.wt + b_q.wt};
				k_q     <= hsize_q[HEAP_AW-1:0];
				hsize_q <= hsize_q + 1'b1;
				next_q  <= next_q + 1'b1;
			end
			UOP_IN_CMP: if (x_q.wt < heap_rdata.wt) k_q <= parent;
			UOP_WK_INIT: begin
				cur_q  <= '{node: heap_rdata.node, depth: '0, bits: '0};
				sp_q   <= '0;
				wout_q <= '0;
			end
			UOP_WK_LEAF: wout_q <= wout_q + 1'b1;
			UOP_WK_PUSH: begin
				cur_q <= '{node: child_rdata.left, depth: depth_p1,
					bits: {cur_q.bits[CODE_W-2:0], 1'b0}};
				sp_q  <= sp_q + 1'b1;
			end
			UOP_WK_POP:  sp_q  <= spm1;
			UOP_WK_LOAD: cur_q <= stk_rdata;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (uop == UOP_RD_OUT) begin
			sym_cnt_q <= dist_q;
			if (!built_q || ({1'b0, idx_q} >= dist_q)) begin
				ent_sym_q   <= '0;
				code_bits_q <= '0;
				code_len_q  <= '0;
				status_q    <= ST_ERR;
			end else begin
				ent_sym_q   <= code_rdata.sym;
				code_bits_q <= code_rdata.bits;
				code_len_q  <= code_rdata.len;
				status_q    <= code_rdata.too_long ? ST_LONG : ST_OK;
			end
		end else if (uop == UOP_FIN_OUT) begin
			sym_cnt_q   <= dist_q;
			ent_sym_q   <= '0;
			code_bits_q <= '0;
			code_len_q  <= '0;
			status_q    <= any_long_q ? ST_LONG : ST_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol_count = sym_cnt_q;
	assign entry_symbol = ent_sym_q;
	assign code_bits    = code_bits_q;
	assign code_length  = code_len_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// File: rtl/core/huffman_code_builder_core.sv
// Count byte: a repeat byte steps through accept, map read, count read and
//   count write; a new byte skips the count read-modify-write.
// Read entry: accept, code table read, then result load once the output is free.
// Finish: heap copy, sift-down heapify, merges with sift and insert steps, then
//   the tree walk; the heap RAM, with one read and one write port, sets the pace.
// Reset clears counters, seen flags and the built flag; tables need no clearing.
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Byte frequency counter and Huffman code table builder, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [hcb_pkg::OP_W-1:0]    op,
	input  wire logic [hcb_pkg::SYM_W-1:0]   data_byte,
	input  wire logic [hcb_pkg::IDX_W-1:0]   entry_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [hcb_pkg::DIST_W-1:0]       symbol_count,
	output logic [hcb_pkg::SYM_W-1:0]        entry_symbol,
	output logic [hcb_pkg::CODE_W-1:0]       code_bits,
	output logic [hcb_pkg::LEN_W-1:0]        code_length,
	output logic [hcb_pkg::STAT_W-1:0]       status
);

	import hcb_pkg::*;

	hcb_cmd_t  cmd;
	hcb_stat_t stat;

	hcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.data_byte    (data_byte),
		.entry_index  (entry_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol_count (symbol_count),
		.entry_symbol (entry_symbol),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.status       (status)
	);

endmodule

`default_nettype wire

// File: rtl/core/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_builder_core_defines.svh"

module hcb_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [hcb_pkg::DIST_W-1:0]  symbol_count,
	input wire logic [hcb_pkg::SYM_W-1:0]   entry_symbol,
	input wire logic [hcb_pkg::CODE_W-1:0]  code_bits,
	input wire logic [hcb_pkg::LEN_W-1:0]   code_length,
	input wire logic [hcb_pkg::STAT_W-1:0]  status
);

	import hcb_pkg::*;

	`HCB_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(code_bits) && $stable(status))

	`HCB_ASSERT_IMP(a_err_zero, out_valid && status == ST_ERR,
		entry_symbol == '0 && code_bits == '0 && code_length == '0)

	`HCB_ASSERT_IMP(a_long_zero, out_valid && status == ST_LONG,
		code_bits == '0 && code_length == '0)

	`HCB_ASSERT_IMP(a_fields_range, out_valid,
		(status == ST_OK || status == ST_ERR || status == ST_LONG) &&
		code_length <= LEN_W'(MAX_CODE_LEN) && symbol_count <= DIST_W'(ALPHA_SIZE))

	// code bits never reach above the code length
	`HCB_ASSERT_IMP(a_code_fits, out_valid && status == ST_OK,
		(code_bits >> code_length) == '0)

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.symbol_count (symbol_count),
	.entry_symbol (entry_symbol),
	.code_bits    (code_bits),
	.code_length  (code_length),
	.status       (status)
);

`default_nettype wire

// File: tb/huffman_code_builder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_builder_core_tb
// Counts byte streams into the core, finishes and reads back the code table.
// A scoreboard class rebuilds the same min-heap tree and left-first walk and
// checks every returned code entry and finish status field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_core_tb;
	import hcb_pkg::*;

	typedef struct {
		logic [DIST_W-1:0] cnt;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] st;
	} code_reply_t;

	class huffman_scoreboard;
		bit [7:0]        slot_sym[ALPHA_SIZE];
		int unsigned     slot_hits[ALPHA_SIZE];
		int unsigned     n_sym;
		bit              built;
		longint unsigned wt[NODE_CAP];
		int unsigned     lch[NODE_CAP];
		int unsigned     rch[NODE_CAP];
		int unsigned     heap[ALPHA_SIZE];
		int unsigned     hsz;
		bit [7:0]        c_sym[ALPHA_SIZE];
		bit [47:0]       c_bits[ALPHA_SIZE];
		bit [5:0]        c_len[ALPHA_SIZE];
		bit              c_long[ALPHA_SIZE];
		bit              any_long;
		code_reply_t     pending[$];
		int              errors;

		function void sift_down(int unsigned k);
			int unsigned m, l, r, t;
			forever begin
				m = k;
				l = 2 * k + 1;
				r = 2 * k + 2;
				if (l < hsz && wt[heap[l]] < wt[heap[m]]) m = l;
				if (r < hsz && wt[heap[r]] < wt[heap[m]]) m = r;
				if (m == k) return;
				t = heap[m];
				heap[m] = heap[k];
				heap[k] = t;
				k = m;
			end
		endfunction

		function int unsigned pop_min();
			int unsigned top;
			top = heap[0];
			heap[0] = heap[hsz-1];
			hsz--;
			sift_down(0);
			return top;
		endfunction

		function void push_node(int unsigned nd);
			int unsigned x;
			x = hsz;
			hsz++;
			while (x != 0 && wt[nd] < wt[heap[(x-1)/2]]) begin
				heap[x] = heap[(x-1)/2];
				x = (x - 1) / 2;
			end
			heap[x] = nd;
		endfunction

		function void build_codes();
			int unsigned     nxt, a, b, sp, outi, nd, dp;
			longint unsigned bv;
			int unsigned     st_node[STK_DEPTH];
			int unsigned     st_depth[STK_DEPTH];
			longint unsigned st_bits[STK_DEPTH];
			any_long = 0;
			built = 1;
			if (n_sym == 0) return;
			for (int i = 0; i < n_sym; i++) begin
				wt[i] = 64'(slot_hits[i]);
				heap[i] = i;
			end
			hsz = n_sym;
			if (n_sym >= 2)
				for (int i = (n_sym - 2) / 2; i >= 0; i--) sift_down(i);
			nxt = n_sym;
			while (hsz > 1) begin
				a = pop_min();
				b = pop_min();
				wt[nxt] = wt[a] + wt[b];
				lch[nxt] = a;
				rch[nxt] = b;
				push_node(nxt);
				nxt++;
			end
			st_node[0] = pop_min();
			st_depth[0] = 0;
			st_bits[0] = 0;
			sp = 1;
			outi = 0;
			while (sp > 0) begin
				sp--;
				nd = st_node[sp];
				dp = st_depth[sp];
				bv = st_bits[sp];
				if (nd < n_sym) begin
					c_sym[outi % ALPHA_SIZE] = slot_sym[nd];
					c_long[outi % ALPHA_SIZE] = dp > MAX_CODE_LEN;
					c_bits[outi % ALPHA_SIZE] = (dp > MAX_CODE_LEN) ? 48'd0 : bv[47:0];
					c_len[outi % ALPHA_SIZE] = (dp > MAX_CODE_LEN) ? 6'd0 : dp[5:0];
					if (dp > MAX_CODE_LEN) any_long = 1;
					outi++;
				end else if (sp + 2 <= STK_DEPTH) begin
					st_node[sp] = rch[nd];
					st_depth[sp] = dp + 1;
					st_bits[sp] = (bv << 1) | 1;
					sp++;
					st_node[sp] = lch[nd];
					st_depth[sp] = dp + 1;
					st_bits[sp] = bv << 1;
					sp++;
				end
			end
		endfunction

		// accepted input transaction
		function void note(op_t o, bit [7:0] b, bit [7:0] idx);
			code_reply_t r;
			int unsigned i;
			if (o == OP_COUNT) begin
				for (i = 0; i < n_sym; i++)
					if (slot_sym[i] == b) break;
				if (i < n_sym) begin
					if (slot_hits[i] < 24'hFFFFFF) slot_hits[i]++;
				end else if (n_sym < ALPHA_SIZE) begin
					slot_sym[n_sym] = b;
					slot_hits[n_sym] = 1;
					n_sym++;
				end
				built = 0;
				return;
			end
			if (o == OP_NOP) return;
			r = '{cnt: n_sym[8:0], sym: '0, bits: '0, len: '0, st: ST_OK};
			if (o == OP_FINISH) begin
				build_codes();
				r.st = any_long ? ST_LONG : ST_OK;
			end else if (!built || idx >= n_sym) begin
				r.st = ST_ERR;
			end else begin
				r.sym = c_sym[idx];
				r.bits = c_bits[idx];
				r.len = c_len[idx];
				r.st = c_long[idx] ? ST_LONG : ST_OK;
			end
			pending.push_back(r);
		endfunction

		function void cmp_field(string name, logic [47:0] e, logic [47:0] a);
			if (e !== a) begin
				$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		// accepted result transaction
		function void check(code_reply_t a);
			code_reply_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none actual status %0d",
					$time, a.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp_field("symbol_count", 48'(e.cnt), 48'(a.cnt));
			cmp_field("entry_symbol", 48'(e.sym), 48'(a.sym));
			cmp_field("code_bits", e.bits, a.bits);
			cmp_field("code_length", 48'(e.len), 48'(a.len));
			cmp_field("status", 48'(e.st), 48'(a.st));
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_ready;
	logic [OP_W-1:0]   op = OP_NOP;
	logic [SYM_W-1:0]  data_byte = '0;
	logic [IDX_W-1:0]  entry_index = '0;
	logic              out_valid;
	logic              out_ready = 0;
	logic [DIST_W-1:0] symbol_count;
	logic [SYM_W-1:0]  entry_symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;
	logic [STAT_W-1:0] status;

	huffman_scoreboard sb = new();
	bit calm = 0;
	int sent = 0;
	int stall_left = 0;

	huffman_code_builder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .data_byte(data_byte), .entry_index(entry_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.symbol_count(symbol_count), .entry_symbol(entry_symbol),
		.code_bits(code_bits), .code_length(code_length), .status(status)
	);

	always #5 clk = ~clk;

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 0;
			stall_left--;
		end else begin
			out_ready = 1;
			if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check('{symbol_count, entry_symbol, code_bits, code_length, status});

	task automatic send(op_t o, bit [7:0] b, bit [7:0] idx);
		int gap;
		gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		op = o;
		data_byte = b;
		entry_index = idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note(o, b, idx);
		sent++;
	endtask

	task automatic send_count(bit [7:0] b);
		send(OP_COUNT, b, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_finish();
		send(OP_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_read(bit [7:0] idx);
		send(OP_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// skewed pick from a pool of bytes spread over all bit patterns
	function automatic bit [7:0] pool_byte(int psz);
		int k;
		k = $urandom_range(0, $urandom_range(0, psz - 1));
		return 8'(k * 37 + 11);
	endfunction

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int psz, k;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: not built, empty finish, lone symbol, range, extremes, rebuild
		send_read(0);
		send_finish();
		send_read(0);
		send_count(8'h41);
		send_finish();
		send_read(0);
		send_read(1);
		send(OP_NOP, 8'hFF, 8'hFF);
		send_count(8'h00);
		send_count(8'hFF);
		send_count(8'hFF);
		send_count(8'h41);
		send_count(8'hFF);
		send_finish();
		for (int i = 0; i < 4; i++) send_read(8'(i));
		send_read(8'hFF);
		send_count(8'h00);
		send_read(0);
		send_finish();
		send_finish();
		send_read(2);

		while (sent < 1000) begin
			if ($urandom_range(0, 3) == 0) calm = ~calm;
			psz = 3 + sent / 12;
			if (psz > 60) psz = 60;
			k = $urandom_range(1, 30);
			repeat (k) begin
				case ($urandom_range(0, 19))
					0: send(OP_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					1: send_read(8'($urandom_range(0, 255)));
					default: send_count(pool_byte(psz));
				endcase
			end
			if ($urandom_range(0, 9) != 0) begin
				send_finish();
				if ($urandom_range(0, 5) == 0) send_finish();
				k = $urandom_range(2, 12);
				repeat (k) send_read(8'($urandom_range(0, sb.n_sym + 1)));
				if ($urandom_range(0, 2) == 0) send_read(8'($urandom_range(0, 255)));
			end
		end

		// fill the alphabet, then push more bytes, all repeats that add to existing counts
		calm = 0;
		for (int i = 0; i < 256; i++) send_count(8'(i));
		repeat (20) send_count(8'($urandom_range(0, 255)));
		send_finish();
		repeat (30) send_read(8'($urandom_range(0, 255)));
		calm = 1;
		repeat (20) send_count(8'($urandom_range(0, 255)));
		send_finish();
		for (int i = 0; i < 256; i += 5) send_read(8'(i));
		send_read(255);

		@(negedge clk) in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
